/* design/iphp_pkg.sv */
// Shared types and constants for the IPv4 header parser.
// Used by iphp_front, iphp_queue, iphp_back and ipv4_header_parser.
package iphp_pkg;

  localparam int MIN_HDR = 20;
  localparam logic [3:0] IP_VERSION = 4'd4;

  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = 2;
  localparam int QCNT_BITS = 3;

  // Header field that a byte lands in
  typedef enum logic [3:0] {
    F_NONE,
    F_TOS,
    F_TOTAL,
    F_IDENT,
    F_FLAGS,
    F_TTL,
    F_PROTO,
    F_SRC,
    F_DST
  } field_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SHORT,
    ST_VERSION,
    ST_HDRLEN
  } status_t;

  typedef enum logic [1:0] {
    FK_NONE,
    FK_FIRST,
    FK_MIDDLE,
    FK_LAST
  } frag_t;

  // One classified byte on its way from the front to the back
  typedef struct packed {
    logic [7:0]  data;
    field_t      field;
    logic        cks_hi;
    logic        cks_lo;
    logic        last;
    status_t     status;
    logic [5:0]  hlen;
    logic [15:0] room;
  } entry_t;

  function automatic field_t field_of(input logic [4:0] idx);
    field_t f;
    unique case (idx) inside
      5'd1:               f = F_TOS;
      5'd2, 5'd3:         f = F_TOTAL;
      5'd4, 5'd5:         f = F_IDENT;
      5'd6, 5'd7:         f = F_FLAGS;
      5'd8:               f = F_TTL;
      5'd9:               f = F_PROTO;
      [5'd12:5'd15]:      f = F_SRC;
      [5'd16:5'd19]:      f = F_DST;
      default:            f = F_NONE;
    endcase
    return f;
  endfunction

endpackage

/* design/iphp_front.sv */
// Front end: accepts packet bytes, tracks the byte index and classifies each byte.
// Depends on iphp_pkg.
module iphp_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             end_of_packet,
  input  logic             q_full,
  output logic             push,
  output iphp_pkg::entry_t entry
);

  localparam int RoomBits = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_sat;
  logic [3:0]            ver;
  logic [5:0]            ihl;
  logic                  first;
  logic [3:0]            ver_cur;
  logic [5:0]            ihl_cur;
  logic                  in_hdr;
  logic [RoomBits-1:0]   room_wide;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    first     = (count == '0);
    ver_cur   = first ? data_byte[7:4] : ver;
    ihl_cur   = first ? {data_byte[3:0], 2'b00} : ihl;
    count_sat = (count == CountMax) ? count : count + 1'b1;
    in_hdr    = count < COUNT_BITS'(ihl_cur);

    entry.data   = data_byte;
    entry.field  = (count < COUNT_BITS'(iphp_pkg::MIN_HDR)) ?
                   iphp_pkg::field_of(count[4:0]) : iphp_pkg::F_NONE;
    entry.cks_hi = in_hdr && !count[0];
    entry.cks_lo = in_hdr && count[0];
    entry.last   = end_of_packet;
    entry.hlen   = ihl_cur;

    if (count_sat < COUNT_BITS'(iphp_pkg::MIN_HDR)) begin
      entry.status = iphp_pkg::ST_SHORT;
    end else if (ver_cur != iphp_pkg::IP_VERSION) begin
      entry.status = iphp_pkg::ST_VERSION;
    end else if (ihl_cur < 6'(iphp_pkg::MIN_HDR) || COUNT_BITS'(ihl_cur) > count_sat) begin
      entry.status = iphp_pkg::ST_HDRLEN;
    end else begin
      entry.status = iphp_pkg::ST_OK;
    end

    // bytes past the header, saturated to the payload field width
    room_wide  = RoomBits'(count_sat) - RoomBits'(ihl_cur);
    entry.room = (room_wide > RoomBits'(16'hFFFF)) ? 16'hFFFF : room_wide[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= end_of_packet ? '0 : count_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (push && first) begin
      ver <= data_byte[7:4];
      ihl <= {data_byte[3:0], 2'b00};
    end
  end

endmodule

/* design/iphp_queue.sv */
// Short FIFO of classified bytes between the front end and the back end.
// Depends on iphp_pkg.
module iphp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  iphp_pkg::entry_t wr_entry,
  output logic             full,
  output logic             q_valid,
  input  logic             pop,
  output iphp_pkg::entry_t head
);

  iphp_pkg::entry_t mem [iphp_pkg::QDEPTH];

  logic [iphp_pkg::QPTR_BITS-1:0] wptr;
  logic [iphp_pkg::QPTR_BITS-1:0] rptr;
  logic [iphp_pkg::QCNT_BITS-1:0] cnt;

  assign full    = (cnt == iphp_pkg::QCNT_BITS'(iphp_pkg::QDEPTH));
  assign q_valid = (cnt != '0);
  assign head    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("queue read while empty");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (wptr - rptr) == cnt[iphp_pkg::QPTR_BITS-1:0])
    else $error("queue pointers disagree with occupancy");
`endif

endmodule

/* design/iphp_back.sv */
// Back end: applies classified bytes to the header stores and checksum,
// and builds the result register on the last byte. Depends on iphp_pkg.
module iphp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  iphp_pkg::entry_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       parse_status,
  output logic             header_sum_ok,
  output logic [5:0]       header_len,
  output logic [7:0]       type_of_service,
  output logic [15:0]      datagram_len,
  output logic [15:0]      identification,
  output logic [15:0]      flags_and_offset,
  output logic [7:0]       time_to_live,
  output logic [7:0]       protocol_number,
  output logic [63:0]      address_pair,
  output logic [1:0]       fragment_kind,
  output logic [15:0]      data_len
);

  logic [7:0]  tos, tos_next;
  logic [15:0] total_len, total_len_next;
  logic [15:0] ident, ident_next;
  logic [15:0] flags_off, flags_off_next;
  logic [7:0]  ttl, ttl_next;
  logic [7:0]  proto, proto_next;
  logic [31:0] src_addr, src_addr_next;
  logic [31:0] dst_addr, dst_addr_next;
  logic [15:0] csum, csum_next;
  logic [7:0]  pending, pending_next;
  logic [16:0] sum_wide;
  logic [15:0] sum_fold;
  logic [15:0] pay_raw;
  logic [15:0] pay;
  iphp_pkg::frag_t kind;

  // hold a last byte only while a finished result is still waiting
  assign pop = q_valid && (!head.last || !out_valid || !out_stall);

  always_comb begin
    tos_next       = tos;
    total_len_next = total_len;
    ident_next     = ident;
    flags_off_next = flags_off;
    ttl_next       = ttl;
    proto_next     = proto;
    src_addr_next  = src_addr;
    dst_addr_next  = dst_addr;
    unique case (head.field)
      iphp_pkg::F_TOS:   tos_next       = head.data;
      iphp_pkg::F_TOTAL: total_len_next = {total_len[7:0], head.data};
      iphp_pkg::F_IDENT: ident_next     = {ident[7:0], head.data};
      iphp_pkg::F_FLAGS: flags_off_next = {flags_off[7:0], head.data};
      iphp_pkg::F_TTL:   ttl_next       = head.data;
      iphp_pkg::F_PROTO: proto_next     = head.data;
      iphp_pkg::F_SRC:   src_addr_next  = {src_addr[23:0], head.data};
      iphp_pkg::F_DST:   dst_addr_next  = {dst_addr[23:0], head.data};
      default: ;
    endcase

    // one's-complement add with end-around carry
    sum_wide     = {1'b0, csum} + {1'b0, pending, head.data};
    sum_fold     = sum_wide[15:0] + {15'b0, sum_wide[16]};
    csum_next    = head.cks_lo ? sum_fold : csum;
    pending_next = head.cks_hi ? head.data : pending;

    if (flags_off_next[12:0] == '0) begin
      kind = flags_off_next[13] ? iphp_pkg::FK_FIRST : iphp_pkg::FK_NONE;
    end else begin
      kind = flags_off_next[13] ? iphp_pkg::FK_MIDDLE : iphp_pkg::FK_LAST;
    end

    pay_raw = (total_len_next > {10'b0, head.hlen}) ?
              total_len_next - {10'b0, head.hlen} : 16'd0;
    pay     = (pay_raw > head.room) ? head.room : pay_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      csum      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        csum <= head.last ? 16'd0 : csum_next;
      end
      out_valid <= (out_valid && out_stall) || (pop && head.last);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tos       <= tos_next;
      total_len <= total_len_next;
      ident     <= ident_next;
      flags_off <= flags_off_next;
      ttl       <= ttl_next;
      proto     <= proto_next;
      src_addr  <= src_addr_next;
      dst_addr  <= dst_addr_next;
      pending   <= pending_next;
    end
    if (pop && head.last) begin
      parse_status <= head.status;
      header_len   <= (head.status == iphp_pkg::ST_SHORT) ? 6'd0 : head.hlen;
      if (head.status == iphp_pkg::ST_OK) begin
        header_sum_ok    <= (csum_next == 16'hFFFF);
        type_of_service  <= tos_next;
        datagram_len     <= total_len_next;
        identification   <= ident_next;
        flags_and_offset <= flags_off_next;
        time_to_live     <= ttl_next;
        protocol_number  <= proto_next;
        address_pair     <= {src_addr_next, dst_addr_next};
        fragment_kind    <= kind;
        data_len         <= pay;
      end else begin
        header_sum_ok    <= 1'b0;
        type_of_service  <= '0;
        datagram_len     <= '0;
        identification   <= '0;
        flags_and_offset <= '0;
        time_to_live     <= '0;
        protocol_number  <= '0;
        address_pair     <= '0;
        fragment_kind    <= iphp_pkg::FK_NONE;
        data_len         <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_status != iphp_pkg::ST_OK |->
      data_len == '0 && address_pair == '0 && !header_sum_ok)
    else $error("error result carries nonzero fields");

  a_pay_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_status == iphp_pkg::ST_OK |->
      data_len <= datagram_len && header_len >= 6'(iphp_pkg::MIN_HDR))
    else $error("payload length exceeds total length");
`endif

endmodule

/* design/ipv4_header_parser.sv */
// IPv4 header parser: one byte per clock in unless stalled, one result per packet out.
// out_valid rises once the back end pops the last byte from the queue; that is late only
// while a stalled result keeps earlier bytes waiting. Throughput: one byte per clock
// unless the queue is full; the 4-entry byte queue lets front and back stall apart.
// A last byte waits in the queue only while the previous result is still stalled.
// Reset (rst, synchronous, active high) clears byte count, checksum, queue and out_valid.
module ipv4_header_parser #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  parse_status,
  output logic        header_sum_ok,
  output logic [5:0]  header_len,
  output logic [7:0]  type_of_service,
  output logic [15:0] datagram_len,
  output logic [15:0] identification,
  output logic [15:0] flags_and_offset,
  output logic [7:0]  time_to_live,
  output logic [7:0]  protocol_number,
  output logic [63:0] address_pair,
  output logic [1:0]  fragment_kind,
  output logic [15:0] data_len
);

  logic             q_full;
  logic             q_valid;
  logic             push;
  logic             pop;
  iphp_pkg::entry_t wr_entry;
  iphp_pkg::entry_t head;

  iphp_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet),
    .q_full        (q_full),
    .push          (push),
    .entry         (wr_entry)
  );

  iphp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (pop),
    .head     (head)
  );

  iphp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .parse_status     (parse_status),
    .header_sum_ok    (header_sum_ok),
    .header_len       (header_len),
    .type_of_service  (type_of_service),
    .datagram_len     (datagram_len),
    .identification   (identification),
    .flags_and_offset (flags_and_offset),
    .time_to_live     (time_to_live),
    .protocol_number  (protocol_number),
    .address_pair     (address_pair),
    .fragment_kind    (fragment_kind),
    .data_len         (data_len)
  );

endmodule

/* test/iphp_tb_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the IPv4 header parser: byte-level header predictor plus result queue.
// Depends on iphp_pkg for the status and fragment enums and the header constants.
package iphp_tb_pkg;

  localparam int CNT_BITS = 16;

  typedef struct packed {
    iphp_pkg::status_t status;
    logic        cks_ok;
    logic [5:0]  hlen;
    logic [7:0]  tos;
    logic [15:0] tot;
    logic [15:0] ident;
    logic [15:0] flags;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [63:0] addrs;
    iphp_pkg::frag_t kind;
    logic [15:0] pay;
  } hdr_result_t;

  class hdr_scoreboard;
    hdr_result_t expected_q[$];
    int errors;

    logic [CNT_BITS-1:0] nbytes;
    logic [7:0]  vihl;
    logic [7:0]  tos;
    logic [15:0] tot;
    logic [15:0] ident;
    logic [15:0] flags;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [16:0] csum;
    logic [7:0]  hi_byte;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      nbytes = '0;
      vihl = '0;
      tos = '0;
      tot = '0;
      ident = '0;
      flags = '0;
      ttl = '0;
      proto = '0;
      src = '0;
      dst = '0;
      csum = '0;
      hi_byte = '0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Advance the header state by one accepted byte; queue a result on the last one.
    function void note_byte(logic [7:0] b, logic eop);
      int unsigned idx, ihl, len, pay, room, s;
      hdr_result_t r;

      idx = 32'(nbytes);
      case (idx)
        0:              vihl = b;
        1:              tos = b;
        2, 3:           tot = {tot[7:0], b};
        4, 5:           ident = {ident[7:0], b};
        6, 7:           flags = {flags[7:0], b};
        8:              ttl = b;
        9:              proto = b;
        12, 13, 14, 15: src = {src[23:0], b};
        16, 17, 18, 19: dst = {dst[23:0], b};
        default: ;
      endcase
      ihl = 4 * int'(vihl[3:0]);

      if (idx < ihl) begin
        if (idx[0] == 1'b0) begin
          hi_byte = b;
        end else begin
          s = 32'(csum) + 32'({hi_byte, b});
          csum = 17'((s & 32'hFFFF) + (s >> 16));
        end
      end

      // saturate, never wrap
      if (nbytes != '1) nbytes++;
      if (!eop) return;

      len = 32'(nbytes);
      r = '0;
      if (len < iphp_pkg::MIN_HDR) r.status = iphp_pkg::ST_SHORT;
      else if (vihl[7:4] != iphp_pkg::IP_VERSION) r.status = iphp_pkg::ST_VERSION;
      else if (ihl < iphp_pkg::MIN_HDR || ihl > len) r.status = iphp_pkg::ST_HDRLEN;
      else r.status = iphp_pkg::ST_OK;

      if (r.status != iphp_pkg::ST_SHORT) r.hlen = ihl[5:0];

      if (r.status == iphp_pkg::ST_OK) begin
        if (flags[12:0] == 13'd0) r.kind = flags[13] ? iphp_pkg::FK_FIRST : iphp_pkg::FK_NONE;
        else r.kind = flags[13] ? iphp_pkg::FK_MIDDLE : iphp_pkg::FK_LAST;
        pay = (32'(tot) > ihl) ? 32'(tot) - ihl : 0;
        room = len - ihl;
        if (pay > room) pay = room;
        r.cks_ok = (csum == 17'h0FFFF);
        r.tos = tos;
        r.tot = tot;
        r.ident = ident;
        r.flags = flags;
        r.ttl = ttl;
        r.proto = proto;
        r.addrs = {src, dst};
        r.pay = pay[15:0];
      end

      expected_q.push_back(r);
      clear();
    endfunction

    task cmp(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(hdr_result_t got);
      hdr_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no packet pending, status %0d", got.status));
        return;
      end
      want = expected_q.pop_front();
      cmp("parse_status", got.status, want.status);
      cmp("header_sum_ok", got.cks_ok, want.cks_ok);
      cmp("header_len", got.hlen, want.hlen);
      cmp("type_of_service", got.tos, want.tos);
      cmp("datagram_len", got.tot, want.tot);
      cmp("identification", got.ident, want.ident);
      cmp("flags_and_offset", got.flags, want.flags);
      cmp("time_to_live", got.ttl, want.ttl);
      cmp("protocol_number", got.proto, want.proto);
      cmp("address_pair", got.addrs, want.addrs);
      cmp("fragment_kind", got.kind, want.kind);
      cmp("data_len", got.pay, want.pay);
    endtask
  endclass

endpackage

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Top-level testbench for ipv4_header_parser: directed and random packets, random idling.
// Depends on iphp_pkg (design) and iphp_tb_pkg (scoreboard).
module tb_top;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [7:0] data_byte;
  logic end_of_packet;
  logic out_valid;
  logic out_stall;
  logic [1:0] parse_status;
  logic header_sum_ok;
  logic [5:0] header_len;
  logic [7:0] type_of_service;
  logic [15:0] datagram_len;
  logic [15:0] identification;
  logic [15:0] flags_and_offset;
  logic [7:0] time_to_live;
  logic [7:0] protocol_number;
  logic [63:0] address_pair;
  logic [1:0] fragment_kind;
  logic [15:0] data_len;

  iphp_tb_pkg::hdr_scoreboard board = new();
  iphp_tb_pkg::hdr_result_t seen;
  logic [7:0] pkt[$];
  bit quiet_tx = 0;
  bit quiet_rx = 0;
  bit hold_req = 0;
  int bytes_sent = 0;

  ipv4_header_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .end_of_packet(end_of_packet),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .parse_status(parse_status),
    .header_sum_ok(header_sum_ok),
    .header_len(header_len),
    .type_of_service(type_of_service),
    .datagram_len(datagram_len),
    .identification(identification),
    .flags_and_offset(flags_and_offset),
    .time_to_live(time_to_live),
    .protocol_number(protocol_number),
    .address_pair(address_pair),
    .fragment_kind(fragment_kind),
    .data_len(data_len)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int idle_cycles(bit quiet);
    if (quiet) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [15:0] rand_flags();
    logic [15:0] f;
    f = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 2) == 0) f[12:0] = '0;
    return f;
  endfunction

  // Push a header with the given fields; options are random, checksum right or random.
  task automatic put_header(input logic [3:0] ver, input logic [3:0] ihl_w,
                            input logic [7:0] tos_b, input logic [15:0] tot_len,
                            input logic [15:0] id, input logic [15:0] flg,
                            input logic [7:0] ttl_b, input logic [7:0] proto_b,
                            input logic [63:0] addrs, input bit good_sum);
    logic [7:0] h [0:59];
    int n;
    int unsigned s;
    logic [15:0] ck;
    n = (ihl_w * 4 < 20) ? 20 : ihl_w * 4;
    for (int i = 0; i < 60; i++) h[i] = 8'($urandom_range(0, 255));
    h[0] = {ver, ihl_w};
    h[1] = tos_b;
    h[2] = tot_len[15:8];
    h[3] = tot_len[7:0];
    h[4] = id[15:8];
    h[5] = id[7:0];
    h[6] = flg[15:8];
    h[7] = flg[7:0];
    h[8] = ttl_b;
    h[9] = proto_b;
    h[10] = 8'h00;
    h[11] = 8'h00;
    for (int i = 0; i < 8; i++) h[12 + i] = addrs[63 - 8 * i -: 8];
    s = 0;
    for (int i = 0; i < ihl_w * 4; i += 2) s += 32'({h[i], h[i + 1]});
    while (s >> 16) s = (s & 32'hFFFF) + (s >> 16);
    ck = good_sum ? ~s[15:0] : 16'($urandom_range(0, 65535));
    h[10] = ck[15:8];
    h[11] = ck[7:0];
    for (int i = 0; i < n; i++) pkt.push_back(h[i]);
  endtask

  task automatic put_random_header(input logic [3:0] ver, input logic [3:0] ihl_w,
                                   input logic [15:0] tot_len, input logic [15:0] flg,
                                   input bit good_sum);
    put_header(ver, ihl_w, 8'($urandom_range(0, 255)), tot_len,
               16'($urandom_range(0, 65535)), flg, 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), {$urandom, $urandom}, good_sum);
  endtask

  task automatic add_payload(input int n);
    for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eop, input bit nogap);
    int gap;
    gap = nogap ? 0 : idle_cycles(quiet_tx);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_packet <= eop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(b, eop);
    bytes_sent++;
  endtask

  task automatic send_packet(input bit nogap);
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1, nogap);
    pkt.delete();
  endtask

  // Parseable packet with random content, mostly small; the checksum is usually right
  task automatic put_good_packet();
    int ihl_w, pay_n, actual;
    logic [15:0] tot_len;
    ihl_w = $urandom_range(0, 1) ? 5 : $urandom_range(5, 15);
    pay_n = $urandom_range(0, 24);
    actual = ihl_w * 4 + pay_n;
    case ($urandom_range(0, 2))
      0: tot_len = 16'(actual);
      1: tot_len = 16'($urandom_range(0, 65535));
      default: tot_len = 16'($urandom_range(0, actual + 8));
    endcase
    put_random_header(4'd4, 4'(ihl_w), tot_len, rand_flags(), $urandom_range(0, 9) != 0);
    add_payload(pay_n);
  endtask

  // Receiver: random stall per transaction, one long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 0;
        n = 400;
      end else begin
        n = idle_cycles(quiet_rx);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.status = iphp_pkg::status_t'(parse_status);
      seen.cks_ok = header_sum_ok;
      seen.hlen = header_len;
      seen.tos = type_of_service;
      seen.tot = datagram_len;
      seen.ident = identification;
      seen.flags = flags_and_offset;
      seen.ttl = time_to_live;
      seen.proto = protocol_number;
      seen.addrs = address_pair;
      seen.kind = iphp_pkg::frag_t'(fragment_kind);
      seen.pay = data_len;
      board.check_result(seen);
    end
  end

  initial begin
    #(64'd20_000_000);
    $display("** ipv4_header_parser: FAILED **");
    $finish;
  end

  initial begin
    int n;
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= '0;
    end_of_packet <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // minimal good header, no payload, not fragmented
    put_header(4'd4, 4'd5, 8'h00, 16'd20, 16'h0000, 16'h0000, 8'h00, 8'h00, 64'd0, 1'b1);
    send_packet(1'b0);
    // longest header, all-ones fields, middle fragment, payload clamped to bytes received
    put_header(4'd4, 4'd15, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, '1, 1'b1);
    add_payload(5);
    send_packet(1'b0);
    // first fragment: MF set, offset zero
    put_random_header(4'd4, 4'd5, 16'd28, 16'h2000, 1'b1);
    add_payload(8);
    send_packet(1'b0);
    // last fragment: offset nonzero, MF clear
    put_random_header(4'd4, 4'd6, 16'd30, 16'hDFFF, 1'b1);
    add_payload(6);
    send_packet(1'b0);
    // total length below header length floors payload at zero
    put_random_header(4'd4, 4'd5, 16'd10, 16'h0000, 1'b1);
    add_payload(3);
    send_packet(1'b0);
    // bad checksum
    put_header(4'd4, 4'd5, 8'h12, 16'd20, 16'h3456, 16'h4000, 8'h40, 8'h06, 64'h1, 1'b0);
    send_packet(1'b0);
    // too short: one byte, then nineteen
    pkt.push_back(8'hFF);
    send_packet(1'b0);
    put_random_header(4'd4, 4'd5, 16'd20, 16'h0000, 1'b1);
    void'(pkt.pop_back());
    send_packet(1'b0);
    // wrong version
    put_random_header(4'd6, 4'd5, 16'd20, 16'h0000, 1'b1);
    send_packet(1'b0);
    // header length below minimum, and zero
    put_random_header(4'd4, 4'd4, 16'd20, 16'h0000, 1'b1);
    send_packet(1'b0);
    put_random_header(4'd4, 4'd0, 16'd20, 16'h0000, 1'b1);
    send_packet(1'b0);
    // header length beyond the bytes received
    put_random_header(4'd4, 4'd15, 16'd60, 16'h0000, 1'b1);
    while (pkt.size() > 40) void'(pkt.pop_back());
    send_packet(1'b0);
    // all-zero header
    for (int i = 0; i < 20; i++) pkt.push_back(8'h00);
    send_packet(1'b0);

    // hold the receiver off while the sender keeps offering back to back
    quiet_tx = 1;
    hold_req = 1;
    for (int i = 0; i < 12; i++) begin
      put_random_header(4'd4, 4'd5, 16'd20, rand_flags(), 1'b1);
      add_payload($urandom_range(0, 4));
      send_packet(1'b0);
    end
    quiet_tx = 0;

    while (bytes_sent < 750) begin
      // occasional stretch with no idling on either side
      quiet_tx = ($urandom_range(0, 7) == 0);
      quiet_rx = quiet_tx;
      case ($urandom_range(0, 9))
        7: begin
          n = $urandom_range(1, 19);
          put_random_header(4'd4, 4'd5, 16'd20, rand_flags(), 1'b1);
          while (pkt.size() > n) void'(pkt.pop_back());
        end
        8: begin
          put_random_header(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                            16'($urandom_range(0, 65535)), rand_flags(),
                            1'($urandom_range(0, 1)));
          add_payload($urandom_range(0, 10));
          if ($urandom_range(0, 1)) begin
            n = $urandom_range(20, pkt.size());
            while (pkt.size() > n) void'(pkt.pop_back());
          end
        end
        9: add_payload($urandom_range(1, 70));
        default: put_good_packet();
      endcase
      send_packet(1'b0);
    end
    quiet_tx = 0;
    quiet_rx = 0;
    in_valid <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("** ipv4_header_parser: PASSED **");
    end else begin
      $display("** ipv4_header_parser: FAILED **");
    end
    $finish;
  end

endmodule
